// ===== sv/ogn_pkg.sv =====
package ogn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int CNT_W     = 5;
  localparam int Q_W       = 17;
  localparam int PERS_W    = 17;
  localparam int OCT_W     = 4;
  localparam int IDX_W     = 2;
  localparam int VAL_W     = 16;

  localparam logic [26:0] HASH_MUL = 27'h45d9f3b;
  localparam int          DIAG_Q16 = 46359;
  localparam int          ONE_F    = 65536;

  localparam logic [IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_PERSISTENCE  = 2'd1;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } ctl_t;

  // shift right by 16 with rounding half away from zero
  function automatic logic signed [47:0] rnd16(input logic signed [47:0] v);
    logic [47:0] m;
    logic [47:0] r;
    m = v[47] ? 48'(-v) : 48'(v);
    r = (m + 48'h8000) >> 16;
    return v[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [43:0] mul22(input logic signed [21:0] a,
                                               input logic signed [21:0] b);
    logic signed [43:0] ea;
    logic signed [43:0] eb;
    ea = 44'(a);
    eb = 44'(b);
    return ea * eb;
  endfunction

endpackage

// ===== sv/ogn_cell.sv =====
module ogn_cell import ogn_pkg::*; #(
  parameter int INDEX = 0,
  parameter int AMP_W = 24,
  parameter int AS_W  = 28,
  parameter int TW    = 45
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ctl_t                ctl_in,
  input  logic [COORD_W-1:0]  x_in,
  input  logic [COORD_W-1:0]  y_in,
  output ctl_t                ctl_out,
  output logic [COORD_W-1:0]  x_out,
  output logic [COORD_W-1:0]  y_out,
  input  logic [AMP_W-1:0]    amp_in,
  input  logic [PERS_W-1:0]   pers,
  output logic [AMP_W-1:0]    amp_out,
  input  logic [TW-1:0]       total_in,
  input  logic [AS_W-1:0]     ampsum_in,
  output logic                acc_valid,
  output logic [TW-1:0]       total_out,
  output logic [AS_W-1:0]     ampsum_out
);

  ctl_t ctl_pipe [1:10];

  logic [15:0] fx [1:3];
  logic [15:0] fy [1:3];

  logic [34:0] h1 [0:3];
  logic [18:0] h2 [0:3];

  logic signed [43:0] fpx [1:4];
  logic signed [43:0] fpy [1:4];

  logic signed [17:0] axis [0:3];
  logic signed [34:0] dprod [0:3];
  logic               diag [0:3];
  logic signed [17:0] g4 [0:3];
  logic signed [17:0] g5 [0:3];

  logic [16:0] fu5, fv5, fv6, fv7;
  logic signed [39:0] pa, pb;
  logic signed [17:0] g00_6, g01_6;
  logic signed [19:0] x1_7, x2_7, x1_8;
  logic signed [41:0] d8;
  logic [16:0] ov;
  logic [AMP_W+16:0] prod;

  logic [AMP_W+16:0] amp_prod;
  assign amp_prod = (AMP_W + 17)'(amp_in) * (AMP_W + 17)'(pers);

  // amplitude chain follows the register continuously
  always_ff @(posedge clk) begin
    amp_out <= AMP_W'((amp_prod + (AMP_W + 17)'(32768)) >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
      ctl_out.cnt <= '0;
      for (int s = 1; s <= 10; s++) begin
        ctl_pipe[s].valid <= 1'b0;
        ctl_pipe[s].cnt <= '0;
      end
      acc_valid <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
      ctl_pipe[1] <= ctl_in;
      for (int s = 2; s <= 10; s++) ctl_pipe[s] <= ctl_pipe[s-1];
      acc_valid <= ctl_pipe[10].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic [8:0]  cxc;
      logic [8:0]  cyc;
      logic [24:0] h0;
      logic [24:0] hu;
      logic [51:0] pr;
      logic [18:0] ht;
      logic [2:0]  sel;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic signed [18:0] sm;
      logic signed [21:0] ts;
      logic signed [21:0] a;
      logic signed [47:0] rr;
      logic signed [20:0] dd;
      logic signed [21:0] n;

      x_out <= {x_in[COORD_W-2:0], 1'b0};
      y_out <= {y_in[COORD_W-2:0], 1'b0};

      // fraction carry
      fx[1] <= x_in[15:0];
      fy[1] <= y_in[15:0];
      for (int s = 2; s <= 3; s++) begin
        fx[s] <= fx[s-1];
        fy[s] <= fy[s-1];
      end

      // hash, first multiply
      for (int c = 0; c < 4; c++) begin
        cxc = {1'b0, x_in[23:16]} + 9'(c >> 1);
        cyc = {1'b0, y_in[23:16]} + 9'(c & 1);
        h0 = {cxc, 7'd0, cyc};
        hu = h0 ^ (h0 >> 16);
        pr = 52'(hu) * 52'(HASH_MUL);
        h1[c] <= pr[34:0];
      end

      // hash, second multiply (only low bits reach the gradient select)
      for (int c = 0; c < 4; c++) begin
        ht = h1[c][18:0] ^ h1[c][34:16];
        h2[c] <= 19'(ht * HASH_MUL[18:0]);
      end

      // gradient select and diagonal product
      for (int c = 0; c < 4; c++) begin
        sel = h2[c][2:0] ^ h2[c][18:16];
        dx = (c >= 2) ? $signed({2'b00, fx[2]}) - 18'sd65536 : $signed({2'b00, fx[2]});
        dy = (c % 2 == 1) ? $signed({2'b00, fy[2]}) - 18'sd65536
                          : $signed({2'b00, fy[2]});
        case (sel[1:0])
          2'd0: begin sm = 19'(dx) + 19'(dy); axis[c] <= dx; end
          2'd1: begin sm = -19'(dx) + 19'(dy); axis[c] <= dy; end
          2'd2: begin sm = -19'(dx) - 19'(dy); axis[c] <= -dx; end
          default: begin sm = 19'(dx) - 19'(dy); axis[c] <= -dy; end
        endcase
        dprod[c] <= 35'(sm) * 35'sd46359;
        diag[c] <= sel[2];
      end

      for (int c = 0; c < 4; c++) begin
        rr = rnd16(48'(dprod[c]));
        g4[c] <= diag[c] ? rr[17:0] : axis[c];
        g5[c] <= g4[c];
      end

      // quintic fade, one multiply per stage
      ts = $signed({6'd0, x_in[15:0]});
      fpx[1] <= mul22(ts, (ts <<< 2) + (ts <<< 1) - 22'sd983040);
      ts = $signed({6'd0, y_in[15:0]});
      fpy[1] <= mul22(ts, (ts <<< 2) + (ts <<< 1) - 22'sd983040);

      rr = rnd16(48'(fpx[1]));
      a = rr[21:0] + 22'sd655360;
      fpx[2] <= mul22($signed({6'd0, fx[1]}), a);
      rr = rnd16(48'(fpy[1]));
      a = rr[21:0] + 22'sd655360;
      fpy[2] <= mul22($signed({6'd0, fy[1]}), a);

      for (int s = 3; s <= 4; s++) begin
        rr = rnd16(48'(fpx[s-1]));
        fpx[s] <= mul22($signed({6'd0, fx[s-1]}), rr[21:0]);
        rr = rnd16(48'(fpy[s-1]));
        fpy[s] <= mul22($signed({6'd0, fy[s-1]}), rr[21:0]);
      end

      rr = rnd16(48'(fpx[4]));
      if (rr < 0) fu5 <= '0;
      else if (rr > 48'sd65536) fu5 <= 17'd65536;
      else fu5 <= rr[16:0];
      rr = rnd16(48'(fpy[4]));
      if (rr < 0) fv5 <= '0;
      else if (rr > 48'sd65536) fv5 <= 17'd65536;
      else fv5 <= rr[16:0];

      // bilinear blend
      pa <= 40'(19'(g5[2]) - 19'(g5[0])) * 40'($signed({1'b0, fu5}));
      pb <= 40'(19'(g5[3]) - 19'(g5[1])) * 40'($signed({1'b0, fu5}));
      g00_6 <= g5[0];
      g01_6 <= g5[1];
      fv6 <= fv5;

      rr = rnd16(48'(pa));
      x1_7 <= 20'(g00_6) + rr[19:0];
      rr = rnd16(48'(pb));
      x2_7 <= 20'(g01_6) + rr[19:0];
      fv7 <= fv6;

      dd = 21'(x2_7) - 21'(x1_7);
      d8 <= 42'(dd) * 42'($signed({1'b0, fv7}));
      x1_8 <= x1_7;

      rr = rnd16(48'(d8));
      n = 22'(x1_8) + rr[21:0] + 22'sd65536;
      if (n < 0) ov <= '0;
      else if (n > 22'sd131072) ov <= 17'd65536;
      else ov <= n[17:1];

      prod <= (AMP_W + 17)'(ov) * (AMP_W + 17)'(amp_in);

      if (ctl_pipe[10].cnt > CNT_W'(INDEX)) begin
        total_out <= total_in + TW'(prod);
        ampsum_out <= ampsum_in + AS_W'(amp_in);
      end else begin
        total_out <= total_in;
        ampsum_out <= ampsum_in;
      end
    end
  end

endmodule

// ===== sv/ogn_div.sv =====
module ogn_div import ogn_pkg::*; #(
  parameter int NUM_W = 45,
  parameter int DEN_W = 28
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             quot_valid,
  output logic [Q_W-1:0]   quot
);

  logic             vl  [0:Q_W];
  logic [NUM_W-1:0] rem [0:Q_W];
  logic [DEN_W-1:0] dn  [0:Q_W];
  logic [Q_W-1:0]   qt  [0:Q_W];

  assign vl[0]  = in_valid;
  assign rem[0] = num;
  assign dn[0]  = den;
  assign qt[0]  = '0;

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int B = Q_W - 1 - s;
    logic [NUM_W-1:0] sh;
    logic             ge;
    assign sh = NUM_W'(dn[s]) << B;
    assign ge = rem[s] >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? rem[s] - sh : rem[s];
        dn[s+1] <= dn[s];
        qt[s+1] <= qt[s] | (Q_W'(ge) << B);
      end
    end
  end

  assign quot_valid = vl[Q_W];
  assign quot = qt[Q_W];

endmodule

// ===== sv/octave_gradient_noise_2d.sv =====
// channel    | direction | signals
// sample     | in        | sample_valid, sample_stall, x_coord, y_coord
// noise      | out       | noise_valid, noise_stall, noise_value
// cfg        | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one sample per cycle sustained while sample_stall is low; a result passes through
// the input register, one hop into each further octave cell, the cell pipeline,
// the 17-stage quotient pipeline and the output register
// rst is synchronous and clears control state; configuration registers return to reset values
// a stalled result parks in a one-entry skid; sample_stall rises only while it is full
module octave_gradient_noise_2d import ogn_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [COORD_W-1:0]  x_coord,
  input  logic [COORD_W-1:0]  y_coord,
  output logic                noise_valid,
  input  logic                noise_stall,
  output logic [VAL_W-1:0]    noise_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [PERS_W-1:0]   cfg_data
);

  // amplitude of octave k stays below 2^(17+k)
  localparam int AMP_W = 16 + MAX_OCTAVES;
  localparam int AS_W  = AMP_W + $clog2(MAX_OCTAVES + 1);
  localparam int TW    = AS_W + 17;

  logic [OCT_W-1:0]  octave_count;
  logic [PERS_W-1:0] persistence;

  logic              skid_valid;
  logic [VAL_W-1:0]  skid_value;
  logic              en;

  // whole pipeline moves in lockstep unless the skid holds a result
  assign en = !skid_valid;
  assign sample_stall = skid_valid;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= OCT_W'(4);
      persistence <= PERS_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OCTAVE_COUNT: octave_count <= cfg_data[OCT_W-1:0];
        REG_PERSISTENCE:  persistence <= cfg_data;
        default: ;
      endcase
    end
  end

  // octave count clipped to 1..MAX_OCTAVES
  logic [CNT_W-1:0] cnt_sat;
  always_comb begin
    if (octave_count == '0) cnt_sat = CNT_W'(1);
    else if (CNT_W'(octave_count) > CNT_W'(MAX_OCTAVES)) cnt_sat = CNT_W'(MAX_OCTAVES);
    else cnt_sat = CNT_W'(octave_count);
  end

  ctl_t               ctl_c   [0:MAX_OCTAVES];
  logic [COORD_W-1:0] x_c     [0:MAX_OCTAVES];
  logic [COORD_W-1:0] y_c     [0:MAX_OCTAVES];
  logic [AMP_W-1:0]   amp_c   [0:MAX_OCTAVES];
  logic [TW-1:0]      tot_c   [0:MAX_OCTAVES];
  logic [AS_W-1:0]    as_c    [0:MAX_OCTAVES];
  logic               accv_c  [1:MAX_OCTAVES];

  // input register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c[0].valid <= 1'b0;
      ctl_c[0].cnt <= '0;
    end else if (en) begin
      ctl_c[0].valid <= sample_valid;
      ctl_c[0].cnt <= cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_c[0] <= x_coord;
      y_c[0] <= y_coord;
    end
  end

  assign amp_c[0] = AMP_W'(ONE_F);
  assign tot_c[0] = '0;
  assign as_c[0]  = '0;

  // one cell per octave; coordinates double and sums ripple along the row
  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_cell
    ogn_cell #(
      .INDEX (k),
      .AMP_W (AMP_W),
      .AS_W  (AS_W),
      .TW    (TW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .ctl_in     (ctl_c[k]),
      .x_in       (x_c[k]),
      .y_in       (y_c[k]),
      .ctl_out    (ctl_c[k+1]),
      .x_out      (x_c[k+1]),
      .y_out      (y_c[k+1]),
      .amp_in     (amp_c[k]),
      .pers       (persistence),
      .amp_out    (amp_c[k+1]),
      .total_in   (tot_c[k]),
      .ampsum_in  (as_c[k]),
      .acc_valid  (accv_c[k+1]),
      .total_out  (tot_c[k+1]),
      .ampsum_out (as_c[k+1])
    );
  end

  logic           dv_valid;
  logic [Q_W-1:0] dv_quot;

  // weighted sum over amplitude sum
  ogn_div #(
    .NUM_W (TW),
    .DEN_W (AS_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (accv_c[MAX_OCTAVES]),
    .num        (tot_c[MAX_OCTAVES]),
    .den        (as_c[MAX_OCTAVES]),
    .quot_valid (dv_valid),
    .quot       (dv_quot)
  );

  // saturate a full-scale quotient
  logic [VAL_W-1:0] result;
  assign result = dv_quot[Q_W-1] ? '1 : dv_quot[VAL_W-1:0];

  logic out_xfer;
  logic push;
  assign out_xfer = noise_valid && !noise_stall;
  assign push = en && dv_valid;

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) skid_valid <= 1'b0;
    end else if (push) begin
      if (noise_valid && !out_xfer) skid_valid <= 1'b1;
      else noise_valid <= 1'b1;
    end else if (out_xfer) begin
      noise_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) noise_value <= skid_value;
    end else if (push) begin
      if (noise_valid && !out_xfer) skid_value <= result;
      else noise_value <= result;
    end
  end

`ifndef SYNTH
  // skid only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> noise_valid)
    else $error("skid holds a result while the output register is empty");

  // a parked result stays until the output drains
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && noise_stall) |=> (skid_valid && $stable(skid_value)))
    else $error("skid entry lost while output stalled");

  // weighted mean never exceeds full scale
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    dv_valid |-> (dv_quot <= Q_W'(65536)))
    else $error("quotient above full scale");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// predicts noise_value for each sample transfer and checks the noise transfers in order
class noise_scoreboard;
  int unsigned oct_cnt;
  int unsigned pers;
  logic [15:0] expected_q[$];
  int          mismatches;

  function new();
    oct_cnt = 4;
    pers = 65536;
    mismatches = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [16:0] data);
    if (idx == ogn_pkg::REG_OCTAVE_COUNT) oct_cnt = data[3:0];
    else if (idx == ogn_pkg::REG_PERSISTENCE) pers = data;
  endfunction

  function longint rnd_shift(longint v, int s);
    longint unsigned half;
    half = 64'd1 << (s - 1);
    if (v >= 0) return longint'(($unsigned(v) + half) >> s);
    return -longint'(($unsigned(-v) + half) >> s);
  endfunction

  function longint grad(longint unsigned cx, longint unsigned cy, longint dx, longint dy);
    longint unsigned h;
    h = (cx << 16) | (cy & 64'hffff);
    h = ((h >> 16) ^ h) * 64'h45d9f3b;
    h = ((h >> 16) ^ h) * 64'h45d9f3b;
    h = (h >> 16) ^ h;
    case (h[2:0])
      3'd0: return dx;
      3'd1: return dy;
      3'd2: return -dx;
      3'd3: return -dy;
      3'd4: return rnd_shift((dx + dy) * ogn_pkg::DIAG_Q16, 16);
      3'd5: return rnd_shift((-dx + dy) * ogn_pkg::DIAG_Q16, 16);
      3'd6: return rnd_shift((-dx - dy) * ogn_pkg::DIAG_Q16, 16);
      default: return rnd_shift((dx - dy) * ogn_pkg::DIAG_Q16, 16);
    endcase
  endfunction

  function longint fade(longint t);
    longint a;
    a = 6 * t - 15 * 65536;
    a = rnd_shift(t * a, 16) + 10 * 65536;
    a = rnd_shift(t * a, 16);
    a = rnd_shift(t * a, 16);
    a = rnd_shift(t * a, 16);
    if (a < 0) a = 0;
    if (a > 65536) a = 65536;
    return a;
  endfunction

  function longint blend(longint a, longint b, longint t);
    return a + rnd_shift((b - a) * t, 16);
  endfunction

  function longint unsigned octave_level(longint unsigned sx, longint unsigned sy);
    longint unsigned cx, cy;
    longint fx, fy, u, v, n;
    cx = (sx >> 16) & 255;
    cy = (sy >> 16) & 255;
    fx = sx & 64'hffff;
    fy = sy & 64'hffff;
    u = fade(fx);
    v = fade(fy);
    n = blend(blend(grad(cx, cy, fx, fy), grad(cx + 1, cy, fx - 65536, fy), u),
              blend(grad(cx, cy + 1, fx, fy - 65536),
                    grad(cx + 1, cy + 1, fx - 65536, fy - 65536), u), v) + 65536;
    if (n < 0) n = 0;
    if (n > 131072) n = 131072;
    return $unsigned(n) >> 1;
  endfunction

  function void note_sample(logic [23:0] x, logic [23:0] y);
    int unsigned cnt;
    longint unsigned amp, total, ampsum, q;
    cnt = oct_cnt;
    amp = 65536;
    total = 0;
    ampsum = 0;
    if (cnt == 0) cnt = 1;
    if (cnt > 8) cnt = 8;
    for (int o = 0; o < cnt; o++) begin
      total += octave_level(64'(x) << o, 64'(y) << o) * amp;
      ampsum += amp;
      amp = (amp * pers + 32768) >> 16;
    end
    q = total / ampsum;
    if (q > 65535) q = 65535;
    expected_q.push_back(q[15:0]);
  endfunction

  function void check_noise(logic [15:0] got);
    logic [15:0] want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected noise transfer: noise_value=%0d", got);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("noise_value mismatch: expected %0d, actual %0d", want, got);
    end
  endfunction
endclass

module testbench;
  import ogn_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_stall;
  logic [COORD_W-1:0] x_coord = '0;
  logic [COORD_W-1:0] y_coord = '0;
  logic               noise_valid;
  logic               noise_stall = 1'b0;
  logic [VAL_W-1:0]   noise_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [PERS_W-1:0]  cfg_data = '0;

  // receiver behavior: 0 never stalls, 1 light, 2 heavy
  int                 stall_mode = 0;
  logic               hold_req = 1'b0;
  int                 hold_left = 0;
  // sender gaps on or off for the current phase
  bit                 gaps_on = 1'b1;

  noise_scoreboard    sb = new();

  octave_gradient_noise_2d dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .x_coord(x_coord), .y_coord(y_coord),
    .noise_valid(noise_valid), .noise_stall(noise_stall), .noise_value(noise_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // noise receiver: random stall pattern, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      noise_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      noise_stall <= 1'b1;
      hold_left <= 300;
    end else begin
      case (stall_mode)
        0: noise_stall <= 1'b0;
        1: noise_stall <= ($urandom_range(0, 3) == 0);
        default: noise_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // every noise transfer goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && noise_valid && !noise_stall) sb.check_noise(noise_value);
  end

  // one sample transfer; valid stays high for the caller's next item
  task automatic send_sample(logic [23:0] x, logic [23:0] y);
    sample_valid <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(x, y);
  endtask

  task automatic pause_sender(int n);
    sample_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every expected result, then let the pipeline drain
  task automatic drain();
    sample_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 24'h03ffff));       // first few cells
      1: return {8'($urandom), 16'hffff - 16'($urandom_range(0, 15))};  // near a cell edge
      2: return {8'($urandom), 16'($urandom_range(0, 15))};
      default: return 24'($urandom);
    endcase
  endfunction

  // random samples in bursts with random gaps
  task automatic random_samples(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n > 0; k++) begin
        send_sample(rand_coord(), rand_coord());
        n--;
      end
      if (gaps_on && $urandom_range(0, 1)) pause_sender($urandom_range(1, 8));
    end
  endtask

  // octave count / persistence settings per phase, extremes included
  int unsigned ph_cnt[10]  = '{1, 8, 0, 15, 3, 8, 2, 6, 5, 4};
  int unsigned ph_pers[10] = '{0, 65536, 32768, 131071, 45000, 0, 98304, 1, 70000, 65535};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, coordinate extremes and cell boundaries
    send_sample(24'h000000, 24'h000000);
    send_sample(24'hffffff, 24'hffffff);
    send_sample(24'hffffff, 24'h000000);
    send_sample(24'h000000, 24'hffffff);
    send_sample(24'h00ffff, 24'h00ffff);
    send_sample(24'hff0000, 24'hff0000);
    send_sample(24'h010000, 24'h00ffff);
    send_sample(24'h7fffff, 24'h800000);
    send_sample(24'h008000, 24'h008000);
    send_sample(24'hfeffff, 24'h00ffff);
    send_sample(24'haaaaaa, 24'h555555);
    send_sample(24'h555555, 24'haaaaaa);
    // pause until everything has come back
    drain();

    // indexes outside the register map are ignored by the block
    write_reg(2'd2, 17'h1ffff);
    write_reg(2'd3, 17'h0);

    for (int p = 0; p < 10; p++) begin
      write_reg(REG_OCTAVE_COUNT, 17'(ph_cnt[p]));
      write_reg(REG_PERSISTENCE, 17'(ph_pers[p]));
      stall_mode = p % 3;
      gaps_on = (p % 4 != 2);
      send_sample(24'h000000, 24'h000000);
      send_sample(24'hffffff, 24'hffffff);
      if (p == 3) begin
        // long hold-off while the sender keeps offering items
        hold_req <= 1'b1;
        send_sample(rand_coord(), rand_coord());
        hold_req <= 1'b0;
      end
      random_samples(190);
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
